// ===== src/pcg32_byte_stream_generator_defines.svh =====
// ----------------------------------------------------------------------------
// PCG byte stream generator assertion macros
// Shared macros for the concurrent checks of the byte stream generator.
// ----------------------------------------------------------------------------
`ifndef PCG32_BYTE_STREAM_GENERATOR_DEFINES_SVH
`define PCG32_BYTE_STREAM_GENERATOR_DEFINES_SVH

// Check a property at every clock edge outside of reset.
`define PCG_BSG_ASSERT_NOW(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property in the cycle that follows a cycle with reset asserted.
`define PCG_BSG_ASSERT_AFTER_RESET(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) !rstn |=> prop) else $error(msg);

`endif

// ===== src/pcg_bsg_pkg.sv =====
// ----------------------------------------------------------------------------
// PCG byte stream generator package
// Constants, types and helper functions shared by the generator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcg_bsg_pkg;

    // Field widths of the stream and configuration ports.
    localparam int BYTE_COUNT_W  = 9;
    localparam int IN_DATA_W     = 16;
    localparam int WORD_W        = 32;
    localparam int VALID_BYTES_W = 3;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 32;

    // Default largest request in bytes.
    localparam int MAX_REQUEST_BYTES_DEFAULT = 256;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_REPRO_SEED = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FAST_SEED  = 2'd1;

    // Byte count of a full output word.
    localparam logic [VALID_BYTES_W-1:0] FULL_WORD_BYTES = 3'd4;

    // Generator and output permutation constants.
    localparam logic [WORD_W-1:0] LCG_MUL = 32'd747796405;
    localparam logic [WORD_W-1:0] LCG_INC = 32'd1729;
    localparam logic [WORD_W-1:0] OUT_MUL = 32'd277803737;
    localparam int RXS_SEL_POS  = 28;
    localparam int RXS_BASE     = 4;
    localparam int XS_SHIFT     = 22;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic                     gen;
        logic                     sel;
        logic [VALID_BYTES_W-1:0] valid_bytes;
        logic                     last;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pipe_ready;
    } status_t;

    // Random xorshift step of the output permutation, ahead of the multiply.
    function automatic logic [WORD_W-1:0] rxs_premix(input logic [WORD_W-1:0] s);
        logic [4:0] shamt;
        shamt = 5'(s[WORD_W-1:RXS_SEL_POS]) + 5'(RXS_BASE);
        return (s >> shamt) ^ s;
    endfunction

endpackage

`default_nettype wire

// ===== src/pcg_bsg_datapath.sv =====
// ----------------------------------------------------------------------------
// PCG byte stream generator datapath
// Generator states, output permutation pipeline and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcg_bsg_datapath (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // Configuration writes
    input  wire logic                                  cfg_we,
    input  wire logic [pcg_bsg_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [pcg_bsg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // Controller interface
    input  wire pcg_bsg_pkg::cmd_t                     cmd,
    output pcg_bsg_pkg::status_t                       status,
    // Result stream
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [pcg_bsg_pkg::WORD_W-1:0]             m_tdata,  // random_word
    output logic [pcg_bsg_pkg::VALID_BYTES_W-1:0]      m_tuser,  // valid_bytes
    output logic                                       m_tlast   // last_word
);

    localparam int W  = pcg_bsg_pkg::WORD_W;
    localparam int VW = pcg_bsg_pkg::VALID_BYTES_W;

    logic [W-1:0]  gen_state_reg [2];
    logic [W-1:0]  cur_state;
    logic [W-1:0]  lcg_next;
    logic [W-1:0]  premix;
    logic [W-1:0]  mix_prod;

    logic          v1_reg;
    logic [W-1:0]  w1_reg;
    logic [VW-1:0] vb1_reg;
    logic          last1_reg;

    logic          out_valid_reg;
    logic [W-1:0]  out_word_reg;
    logic [VW-1:0] out_vb_reg;
    logic          out_last_reg;

    logic          out_free;
    logic          pipe_ready;

    // Pipeline advance conditions.
    assign out_free   = !out_valid_reg || m_tready;
    assign pipe_ready = !v1_reg || out_free;
    assign status.pipe_ready = pipe_ready;

    // State update and first half of the output permutation.
    assign cur_state = gen_state_reg[cmd.sel];
    assign lcg_next  = cur_state * pcg_bsg_pkg::LCG_MUL + pcg_bsg_pkg::LCG_INC;
    assign premix    = pcg_bsg_pkg::rxs_premix(cur_state);
    assign mix_prod  = premix * pcg_bsg_pkg::OUT_MUL;

    // Generator states: loaded by a seed write, stepped once per word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_state_reg[0] <= '0;
            gen_state_reg[1] <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                pcg_bsg_pkg::REG_REPRO_SEED: gen_state_reg[0] <= cfg_wdata;
                pcg_bsg_pkg::REG_FAST_SEED:  gen_state_reg[1] <= cfg_wdata;
                default: ;
            endcase
        end else if (cmd.gen && pipe_ready) begin
            gen_state_reg[cmd.sel] <= lcg_next;
        end
    end

    // Multiply stage control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (pipe_ready) begin
            v1_reg <= cmd.gen;
        end
    end

    // Multiply stage payload.
    always_ff @(posedge aclk) begin
        if (pipe_ready && cmd.gen) begin
            w1_reg    <= mix_prod;
            vb1_reg   <= cmd.valid_bytes;
            last1_reg <= cmd.last;
        end
    end

    // Output register control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= v1_reg;
        end
    end

    // Output register payload, final xorshift applied on the way in.
    always_ff @(posedge aclk) begin
        if (out_free && v1_reg) begin
            out_word_reg <= w1_reg ^ (w1_reg >> pcg_bsg_pkg::XS_SHIFT);
            out_vb_reg   <= vb1_reg;
            out_last_reg <= last1_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;
    assign m_tuser  = out_vb_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== src/pcg_bsg_ctrl.sv =====
// ----------------------------------------------------------------------------
// PCG byte stream generator controller
// Accepts requests and sequences one word command per cycle while the datapath is ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcg_bsg_ctrl #(
    parameter int MAX_REQUEST_BYTES = pcg_bsg_pkg::MAX_REQUEST_BYTES_DEFAULT
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    // Request stream
    input  wire logic                                    s_tvalid,
    output logic                                         s_tready,
    input  wire logic [pcg_bsg_pkg::BYTE_COUNT_W-1:0]    byte_count,
    input  wire logic                                    source_select,
    // Datapath interface
    output pcg_bsg_pkg::cmd_t                            cmd,
    input  wire pcg_bsg_pkg::status_t                    status
);

    localparam int BC_W    = pcg_bsg_pkg::BYTE_COUNT_W;
    localparam int VW      = pcg_bsg_pkg::VALID_BYTES_W;
    localparam int BYTES_W = $clog2(MAX_REQUEST_BYTES + 1);
    localparam logic [BC_W-1:0]    MAX_BC     = BC_W'(MAX_REQUEST_BYTES);
    localparam logic [BYTES_W-1:0] WORD_BYTES = BYTES_W'(4);

    // Controller states.
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic               state_reg, state_next;
    logic [BYTES_W-1:0] rem_reg, rem_next;
    logic               sel_reg, sel_next;
    logic [BC_W-1:0]    count_sat;
    logic               is_last;
    logic [VW-1:0]      word_bytes;

    // Clamp the request to the largest supported size.
    assign count_sat = (byte_count > MAX_BC) ? MAX_BC : byte_count;

    // Bytes carried by the word issued this cycle.
    assign is_last    = (rem_reg <= WORD_BYTES);
    assign word_bytes = is_last ? rem_reg[VW-1:0] : pcg_bsg_pkg::FULL_WORD_BYTES;

    assign s_tready        = (state_reg == ST_IDLE);
    assign cmd.gen         = (state_reg == ST_RUN);
    assign cmd.sel         = sel_reg;
    assign cmd.valid_bytes = word_bytes;
    assign cmd.last        = is_last;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        rem_next   = rem_reg;
        sel_next   = sel_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    rem_next = BYTES_W'(count_sat);
                    sel_next = source_select;
                    if (count_sat != '0) begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (status.pipe_ready) begin
                    rem_next = rem_reg - BYTES_W'(word_bytes);
                    if (is_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rem_reg   <= '0;
            sel_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
            sel_reg   <= sel_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/pcg32_byte_stream_generator.sv =====
// ----------------------------------------------------------------------------
// PCG32 byte stream generator
// Two seeded RXS-M-XS generators streaming random words.
// ----------------------------------------------------------------------------
// A request carries a generator select in s_tuser and a byte count in
// s_tdata; counts above MAX_REQUEST_BYTES are clamped and a count of zero is
// taken without producing output. The request is taken while the controller
// is idle, then one 32-bit word is produced per cycle while the pipeline is
// not stalled, and no new request is taken until the last word of the request
// is issued. Each word takes one 32x32 multiply-add step of the generator
// state register. Results leave through a multiply stage and an output
// register, and a stalled output holds the pipeline. Writing a seed register
// reloads that generator at once; both generators start at zero.
`timescale 1ns / 1ps
`default_nettype none

module pcg32_byte_stream_generator #(
    parameter int MAX_REQUEST_BYTES = pcg_bsg_pkg::MAX_REQUEST_BYTES_DEFAULT
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // Configuration write port
    input  wire logic                                  cfg_we,
    input  wire logic [pcg_bsg_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [pcg_bsg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // Request stream
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [pcg_bsg_pkg::IN_DATA_W-1:0]     s_tdata,  // byte_count[8:0]
    input  wire logic                                  s_tuser,  // source_select
    // Result stream
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [pcg_bsg_pkg::WORD_W-1:0]             m_tdata,  // random_word
    output logic [pcg_bsg_pkg::VALID_BYTES_W-1:0]      m_tuser,  // valid_bytes
    output logic                                       m_tlast   // last_word
);

    pcg_bsg_pkg::cmd_t    cmd;
    pcg_bsg_pkg::status_t status;

    // Request sequencer.
    pcg_bsg_ctrl #(
        .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .byte_count    (s_tdata[pcg_bsg_pkg::BYTE_COUNT_W-1:0]),
        .source_select (s_tuser),
        .cmd           (cmd),
        .status        (status)
    );

    // Generators and output pipeline.
    pcg_bsg_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// ===== src/pcg_bsg_checker.sv =====
// ----------------------------------------------------------------------------
// PCG byte stream generator checker
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "pcg32_byte_stream_generator_defines.svh"

module pcg_bsg_checker (
    input wire logic                                  aclk,
    input wire logic                                  aresetn,
    input wire logic                                  m_tvalid,
    input wire logic                                  m_tready,
    input wire logic [pcg_bsg_pkg::WORD_W-1:0]        m_tdata,
    input wire logic [pcg_bsg_pkg::VALID_BYTES_W-1:0] m_tuser,
    input wire logic                                  m_tlast
);

    // A stalled transaction keeps its word.
    `PCG_BSG_ASSERT_NOW(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

    // No result is offered right after reset.
    `PCG_BSG_ASSERT_AFTER_RESET(a_reset_idle, aclk, aresetn, !m_tvalid, "result valid after reset")

    // Every word but the final one of a request is full.
    `PCG_BSG_ASSERT_NOW(a_full_words, aclk, aresetn, m_tvalid && !m_tlast |-> m_tuser == pcg_bsg_pkg::FULL_WORD_BYTES, "partial word before the last one")

    // A word always carries between one and four bytes.
    `PCG_BSG_ASSERT_NOW(a_vb_range, aclk, aresetn, m_tvalid |-> m_tuser != '0 && m_tuser <= pcg_bsg_pkg::FULL_WORD_BYTES, "valid byte count out of range")

endmodule

bind pcg32_byte_stream_generator pcg_bsg_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== bench/pcg32_byte_stream_generator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCG32 byte stream generator testbench
// Sends byte-count requests to both generators and checks every output word
// (random word, valid byte count and last flag) against a predictor that
// keeps its own copy of both generator states and of the seed reloads.
// ----------------------------------------------------------------------------

module pcg32_byte_stream_generator_tb;

    // Widths and constants taken from the generator package.
    localparam int CFG_INDEX_W   = pcg_bsg_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W    = pcg_bsg_pkg::CFG_DATA_W;
    localparam int WORD_W        = pcg_bsg_pkg::WORD_W;
    localparam int VALID_BYTES_W = pcg_bsg_pkg::VALID_BYTES_W;
    localparam int BYTE_COUNT_W  = pcg_bsg_pkg::BYTE_COUNT_W;
    localparam int IN_DATA_W     = pcg_bsg_pkg::IN_DATA_W;
    localparam int MAX_REQUEST_BYTES_DEFAULT = pcg_bsg_pkg::MAX_REQUEST_BYTES_DEFAULT;
    localparam int RXS_SEL_POS   = pcg_bsg_pkg::RXS_SEL_POS;
    localparam int RXS_BASE      = pcg_bsg_pkg::RXS_BASE;
    localparam int XS_SHIFT      = pcg_bsg_pkg::XS_SHIFT;
    localparam logic [WORD_W-1:0] LCG_MUL = pcg_bsg_pkg::LCG_MUL;
    localparam logic [WORD_W-1:0] LCG_INC = pcg_bsg_pkg::LCG_INC;
    localparam logic [WORD_W-1:0] OUT_MUL = pcg_bsg_pkg::OUT_MUL;
    localparam logic [VALID_BYTES_W-1:0] FULL_WORD_BYTES = pcg_bsg_pkg::FULL_WORD_BYTES;
    localparam logic [CFG_INDEX_W-1:0] REG_REPRO_SEED = pcg_bsg_pkg::REG_REPRO_SEED;
    localparam logic [CFG_INDEX_W-1:0] REG_FAST_SEED  = pcg_bsg_pkg::REG_FAST_SEED;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 48;

    // Indexes past the register list; writes to them must be ignored.
    localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_HI = 2'd3;

    // One expected output word.
    typedef struct {
        logic [WORD_W-1:0]        word;
        logic [VALID_BYTES_W-1:0] valid_bytes;
        logic                     last;
    } pcg_word_t;

    // Predictor and scoreboard of the generated word stream.
    class pcg_word_scoreboard;
        logic [WORD_W-1:0] gen_state [2];
        pcg_word_t         pending_words [$];
        int                error_count;
        int                words_checked;
        int                requests_seen;
        int                empty_requests;
        int                clamped_requests;

        function new();
            gen_state[0] = '0;
            gen_state[1] = '0;
        endfunction

        // A seed write reloads the matching generator; other indexes do nothing.
        function void load_seed(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == REG_REPRO_SEED) begin
                gen_state[0] = value;
            end else if (idx == REG_FAST_SEED) begin
                gen_state[1] = value;
            end
        endfunction

        // Random xorshift, multiply, then fixed xorshift of the state.
        function logic [WORD_W-1:0] permute(logic [WORD_W-1:0] s);
            logic [4:0]        amount;
            logic [WORD_W-1:0] w;
            amount = {1'b0, s[WORD_W-1:RXS_SEL_POS]} + 5'(RXS_BASE);
            w = ((s >> amount) ^ s) * OUT_MUL;
            return w ^ (w >> XS_SHIFT);
        endfunction

        // Expand one accepted request into its expected words.
        function void note_request(logic sel, logic [BYTE_COUNT_W-1:0] count);
            int                n;
            int                nwords;
            logic [WORD_W-1:0] s;
            pcg_word_t         w;
            requests_seen++;
            n = count;
            if (n > MAX_REQUEST_BYTES_DEFAULT) begin
                n = MAX_REQUEST_BYTES_DEFAULT;
                clamped_requests++;
            end
            if (n == 0) begin
                empty_requests++;
                return;
            end
            nwords = (n + 3) / 4;
            s = gen_state[sel];
            for (int k = 0; k < nwords; k++) begin
                w.word        = permute(s);
                w.last        = (k == nwords - 1);
                w.valid_bytes = w.last ? VALID_BYTES_W'(n - 4 * k) : FULL_WORD_BYTES;
                pending_words.push_back(w);
                s = s * LCG_MUL + LCG_INC;
            end
            gen_state[sel] = s;
        endfunction

        task report_mismatch(string what);
            $display("[%0t] MISMATCH: %s", $realtime, what);
            error_count++;
        endtask

        // Compare one output transaction with the oldest expected word.
        task check_word(logic [WORD_W-1:0] word, logic [VALID_BYTES_W-1:0] vb, logic last);
            pcg_word_t w;
            if (pending_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", word));
                return;
            end
            w = pending_words.pop_front();
            words_checked++;
            if (word !== w.word)
                report_mismatch($sformatf("word %h, expected %h", word, w.word));
            if (vb !== w.valid_bytes)
                report_mismatch($sformatf("valid bytes %0d, expected %0d", vb, w.valid_bytes));
            if (last !== w.last)
                report_mismatch($sformatf("last %b, expected %b", last, w.last));
        endtask
    endclass

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_wdata = '0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_W-1:0]     s_tdata   = '0;
    logic                     s_tuser   = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [WORD_W-1:0]        m_tdata;
    logic [VALID_BYTES_W-1:0] m_tuser;
    logic                     m_tlast;

    int                 src_idle_pct = 7;
    int                 dst_idle_pct = 64;
    int                 cycle_count  = 0;
    pcg_word_scoreboard model        = new();

    pcg32_byte_stream_generator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Clock with an 8 ns period.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Watchdog on the run length.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("pcg32_byte_stream_generator regression: fail");
            $finish;
        end
    end

    // Random backpressure on the result stream.
    initial begin
        forever begin
            @(negedge aclk);
            m_tready = ($urandom_range(99) >= dst_idle_pct);
        end
    end

    // Check every accepted result transaction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            model.check_word(m_tdata, m_tuser, m_tlast);
    end

    // Send one request, idling first at the sender's rate.
    task automatic send_request(input logic sel, input logic [BYTE_COUNT_W-1:0] count);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = sel;
        s_tdata  = IN_DATA_W'(count);
        do @(posedge aclk); while (!s_tready);
        model.note_request(sel, count);
    endtask

    // Stop sending and let every expected word arrive, plus a short pad
    // for a zero-count request that may still be in flight.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (model.pending_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_seed(input logic [CFG_INDEX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(posedge aclk);
        model.load_seed(idx, value);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // Mostly short requests, some long ones and some above the clamp.
    function automatic logic [BYTE_COUNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 5)  return '0;
        if (r < 70) return BYTE_COUNT_W'($urandom_range(32, 1));
        if (r < 88) return BYTE_COUNT_W'($urandom_range(256, 33));
        return BYTE_COUNT_W'($urandom_range(511, 257));
    endfunction

    // Random requests under one idling setting, with a full drain midway and at random points.
    task automatic run_random(input int n_items, input int src_pct, input int dst_pct);
        src_idle_pct = src_pct;
        dst_idle_pct = dst_pct;
        for (int i = 0; i < n_items; i++) begin
            if (i == n_items / 2 || $urandom_range(24) == 0)
                wait_idle();
            send_request(1'(($urandom_range(1))), pick_count());
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed requests from the reset state: both generators at zero.
        send_request(1'b0, 9'd0);
        send_request(1'b0, 9'd1);
        send_request(1'b0, 9'd2);
        send_request(1'b0, 9'd3);
        send_request(1'b0, 9'd4);
        send_request(1'b0, 9'd5);
        send_request(1'b1, 9'd8);
        send_request(1'b1, 9'd256);
        send_request(1'b0, 9'd0);
        wait_idle();

        // Reload both generators at the extremes and try the clamp.
        write_seed(REG_REPRO_SEED, 32'h0000_0000);
        write_seed(REG_FAST_SEED, 32'hFFFF_FFFF);
        send_request(1'b0, 9'd7);
        send_request(1'b1, 9'd511);
        send_request(1'b1, 9'd0);
        send_request(1'b0, 9'd257);
        send_request(1'b1, 9'd255);
        send_request(1'b0, 9'd256);
        wait_idle();

        // Sender busy, receiver often stalled; spare indexes are written too.
        write_seed(REG_REPRO_SEED, 32'hFFFF_FFFF);
        write_seed(REG_FAST_SEED, $urandom);
        write_seed(SPARE_INDEX_LO, $urandom);
        write_seed(SPARE_INDEX_HI, $urandom);
        run_random(PHASE_ITEMS, 7, 64);
        wait_idle();

        // Sender often idle, receiver mostly ready.
        write_seed(REG_REPRO_SEED, $urandom);
        write_seed(REG_FAST_SEED, 32'hFFFF_FFFF);
        run_random(PHASE_ITEMS, 64, 7);
        wait_idle();

        // Full rate on both sides, generators back at zero.
        write_seed(REG_REPRO_SEED, 32'h0000_0000);
        write_seed(REG_FAST_SEED, 32'h0000_0000);
        run_random(PHASE_ITEMS, 0, 0);
        wait_idle();

        $display("Run covered %0d requests (%0d of zero bytes, %0d clamped) on both generators.",
                 model.requests_seen, model.empty_requests, model.clamped_requests);
        $display("%0d output words checked under three idling mixes and five seed settings.",
                 model.words_checked);
        if (model.error_count == 0) begin
            $display("pcg32_byte_stream_generator regression: pass");
        end else begin
            $display("pcg32_byte_stream_generator regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/pcg_bsg_pkg.sv
src/pcg_bsg_datapath.sv
src/pcg_bsg_ctrl.sv
src/pcg32_byte_stream_generator.sv
src/pcg_bsg_checker.sv
bench/pcg32_byte_stream_generator_tb.sv
